/* rtl/bol_pkg.sv */
// ----------------------------------------------------------------------------
// bol_pkg
// Shared sizes, command and status codes and beat types for the bounded
// ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

    // Sizing
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 2;
    localparam int ENTRY_W  = 6;
    // width that holds both a position and count+1
    localparam int PCMP_W   = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_AT   = 3'd6;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Command beat
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_cmd_beat;

    // Result beat
    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic                    last;
        logic [ST_W-1:0]         status;
        logic [ENTRY_W-1:0]      entry_count;
    } t_res_beat;

endpackage

/* rtl/bol_ram.sv */
// ----------------------------------------------------------------------------
// bol_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bounded_ordered_list.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of signed 32-bit values held in one RAM, head at address 0.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Commands that
// fail their checks, and read-out of an empty list, answer with one result
// beat on the next cycle and leave busy low, so one such command can be
// issued every cycle. Read-out of n entries keeps busy high and streams one
// result beat per cycle, head first, last beat marked. Insert or delete at
// slot s (0-based) in a list of n entries moves every entry from s onward
// (insert) or behind s (delete) by one place through the RAM, one entry per
// cycle, and then reports; busy stays high until the report is issued. The
// one-entry-per-cycle rate is set by the single RAM read port and write
// port. Result beats carry a one-cycle strobe and cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
module bounded_ordered_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bol_pkg::t_cmd_beat i_cmd_beat,
    output logic               o_res_strobe,
    output bol_pkg::t_res_beat o_res_beat
);

    import bol_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    // Control state
    logic [1:0]       r_state,   n_state;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_left,    n_left;
    logic             r_p_vld,   n_p_vld;
    logic             r_out_stb, n_out_stb;

    // Payload state
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0] r_p_waddr, n_p_waddr;
    logic              r_p_last,  n_p_last;
    logic              r_up,      n_up;
    logic [ADDR_W-1:0] r_slot,    n_slot;
    logic [VAL_W-1:0]  r_val,     n_val;
    t_res_beat         r_out,     n_out;

    // RAM port
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [VAL_W-1:0]  w_rdata;

    // Command checks
    logic [PCMP_W-1:0] w_cnt;
    logic [PCMP_W-1:0] w_pos;
    logic [PCMP_W-1:0] w_ins_p;
    logic [PCMP_W-1:0] w_del_p;
    logic [ST_W-1:0]   w_ins_st;
    logic [ST_W-1:0]   w_del_st;
    logic              w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    bol_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Position and status of the incoming command
    always_comb begin
        w_cnt = PCMP_W'(r_count);
        w_pos = PCMP_W'(i_cmd_beat.position);

        case (i_cmd_beat.cmd)
            CMD_INS_HEAD: w_ins_p = PCMP_W'(1);
            CMD_INS_TAIL: w_ins_p = w_cnt + PCMP_W'(1);
            default:      w_ins_p = w_pos;
        endcase

        case (i_cmd_beat.cmd)
            CMD_DEL_HEAD: w_del_p = PCMP_W'(1);
            CMD_DEL_TAIL: w_del_p = w_cnt;
            default:      w_del_p = w_pos;
        endcase

        if (w_ins_p == '0 || w_ins_p > w_cnt + PCMP_W'(1)) begin
            w_ins_st = ST_BADPOS;
        end else if (r_count >= CNT_W'(CAPACITY)) begin
            w_ins_st = ST_FULL;
        end else begin
            w_ins_st = ST_OK;
        end

        if (i_cmd_beat.cmd == CMD_DEL_AT && w_pos == '0) begin
            w_del_st = ST_BADPOS;
        end else if (r_count == '0) begin
            w_del_st = ST_EMPTY;
        end else if (w_del_p > w_cnt) begin
            w_del_st = ST_BADPOS;
        end else begin
            w_del_st = ST_OK;
        end
    end

    // Sequencer: read-out stream and RAM shift loop
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_p_vld   = 1'b0;
        n_out_stb = 1'b0;
        n_rd_addr = r_rd_addr;
        n_p_waddr = r_p_waddr;
        n_p_last  = r_p_last;
        n_up      = r_up;
        n_slot    = r_slot;
        n_val     = r_val;
        n_out     = r_out;
        w_we      = 1'b0;
        w_waddr   = r_p_waddr;
        w_wdata   = w_rdata;
        w_raddr   = r_rd_addr;

        // one RAM read per cycle while entries remain
        if (r_state != S_IDLE && r_left != '0) begin
            n_rd_addr = r_up ? r_rd_addr - ADDR_W'(1) : r_rd_addr + ADDR_W'(1);
            n_p_waddr = r_up ? r_rd_addr + ADDR_W'(1) : r_rd_addr - ADDR_W'(1);
            n_left    = r_left - CNT_W'(1);
            n_p_vld   = 1'b1;
            n_p_last  = (r_left == CNT_W'(1));
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_stb = 1'b1;
                    n_out.item_value  = '0;
                    n_out.last        = 1'b1;
                    n_out.entry_count = ENTRY_W'(r_count);
                    case (i_cmd_beat.cmd) inside
                        CMD_READ: begin
                            n_out.status = ST_EMPTY;
                            if (r_count != '0) begin
                                n_out_stb = 1'b0;
                                n_state   = S_READ;
                                n_up      = 1'b0;
                                n_rd_addr = '0;
                                n_left    = r_count;
                            end
                        end
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                            n_out.status = w_ins_st;
                            if (w_ins_st == ST_OK) begin
                                n_out_stb = 1'b0;
                                n_state   = S_SHIFT;
                                n_up      = 1'b1;
                                n_slot    = ADDR_W'(w_ins_p - PCMP_W'(1));
                                n_val     = i_cmd_beat.value;
                                n_left    = CNT_W'(w_cnt - (w_ins_p - PCMP_W'(1)));
                                n_rd_addr = ADDR_W'(w_cnt - PCMP_W'(1));
                            end
                        end
                        CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
                            n_out.status = w_del_st;
                            if (w_del_st == ST_OK) begin
                                n_out_stb = 1'b0;
                                n_state   = S_SHIFT;
                                n_up      = 1'b0;
                                n_left    = CNT_W'(w_cnt - w_del_p);
                                n_rd_addr = ADDR_W'(w_del_p);
                            end
                        end
                        default: begin
                            n_out.status = ST_BADPOS;
                        end
                    endcase
                end
            end

            S_READ: begin
                // RAM data of the previous read goes out as a beat
                if (r_p_vld) begin
                    n_out_stb         = 1'b1;
                    n_out.item_value  = w_rdata;
                    n_out.last        = r_p_last;
                    n_out.status      = ST_OK;
                    n_out.entry_count = ENTRY_W'(r_count);
                    if (r_p_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_SHIFT: begin
                if (r_p_vld) begin
                    // write back the entry read last cycle, one place over
                    w_we    = 1'b1;
                    w_waddr = r_p_waddr;
                    w_wdata = w_rdata;
                end else if (r_left == '0) begin
                    // shift done: place new value or drop the entry
                    if (r_up) begin
                        w_we    = 1'b1;
                        w_waddr = r_slot;
                        w_wdata = r_val;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_out_stb         = 1'b1;
                    n_out.item_value  = '0;
                    n_out.last        = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.entry_count = ENTRY_W'(n_count);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_p_vld   <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_p_vld   <= n_p_vld;
            r_out_stb <= n_out_stb;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_p_waddr <= n_p_waddr;
        r_p_last  <= n_p_last;
        r_up      <= n_up;
        r_slot    <= n_slot;
        r_val     <= n_val;
        r_out     <= n_out;
    end

    assign o_res_strobe = r_out_stb;
    assign o_res_beat   = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_p_vld)
        else $error("RAM read in flight while idle");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (int'(w_waddr) < CAPACITY))
        else $error("RAM write beyond capacity");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_count != r_count) |-> n_out_stb)
        else $error("count changed without a result beat");

    a_read_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && r_state == S_READ) |=> o_res_strobe)
        else $error("read-out data lost");

endmodule
